@@ src/rood_pkg.sv @@
// ----------------------------------------------------------------------------
// rood_pkg
// Shared constants for the range outlier obstacle detector: group size,
// field widths, status codes, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package rood_pkg;

    // Number of ranging samples in one group.
    localparam int SAMPLES = 3;

    localparam int DIST_W = 16;
    localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    // Wide enough to hold the count of good samples, SAMPLES included.
    localparam int CNT_W  = $clog2(SAMPLES + 1);
    localparam int SUM_W  = DIST_W + CNT_W;
    localparam int BIT_W  = $clog2(SUM_W);

    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 2;
    localparam int MASK_W   = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INACTIVE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ALL_FAILED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEAR       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OBSTRUCTION = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [DIST_W-1:0] LOW_LIMIT_RST = 16'd10;
    localparam logic [DIST_W-1:0] CRITICAL_RST  = 16'd20;

endpackage

@@ src/range_outlier_obstacle_detector_unit.sv @@
// ----------------------------------------------------------------------------
// range_outlier_obstacle_detector_unit
// Collects groups of ranging samples, averages the good ones, rejects
// outliers and reports whether the kept samples show an obstruction ahead.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: distance; tuser: sensor_ok, moving_forward
//  m_axis    out        tdata: kept_count, obstruction_count, mask; tuser: status
//  cfg       in         cfg_index selects enable, low limit or critical distance
//
//  A gated sample is accepted and then loads a result. The last sample of a group starts the
//  evaluation: one pass over the store to sum, one quotient bit per cycle in the divider,
//  one pass to check. The divide and the check are skipped when no sample of the group is good.
//  The block is not ready while it evaluates or while a result waits for the output register.
//  Reset clears the group position and sets enable 0, low limit 10, critical distance 20.
//
module range_outlier_obstacle_detector_unit
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] distance
    input  logic [1:0]                          s_axis_tuser,  // [0] sensor_ok, [1] moving_forward

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] kept_count, [3:2] obstruction_count, [6:4] obstruction_mask, [7] zero
    output logic [7:0]                          m_axis_tdata,
    output logic [rood_pkg::STATUS_W-1:0]       m_axis_tuser,  // [2:0] status

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rood_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rood_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        IDLE,
        SUM,
        DIV,
        CHECK,
        RESULT
    } state_t;

    state_t                               state_reg, state_next;
    logic [rood_pkg::IDX_W-1:0]           pos_reg, pos_next;
    logic [rood_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic [rood_pkg::BIT_W-1:0]           bit_reg, bit_next;
    logic [rood_pkg::SUM_W-1:0]           acc_reg, acc_next;
    logic [rood_pkg::CNT_W-1:0]           rem_reg, rem_next;
    logic [rood_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic [rood_pkg::CNT_W-1:0]           kept_reg, kept_next;
    logic [rood_pkg::CNT_W-1:0]           obs_reg, obs_next;
    logic [rood_pkg::MASK_W-1:0]          mask_reg, mask_next;
    logic [rood_pkg::STATUS_W-1:0]        status_reg, status_next;

    logic                                 m_valid_reg, m_valid_next;
    logic [7:0]                           m_data_reg, m_data_next;
    logic [rood_pkg::STATUS_W-1:0]        m_user_reg, m_user_next;

    logic                                 enable_reg;
    logic [rood_pkg::DIST_W-1:0]          low_reg;
    logic [rood_pkg::DIST_W-1:0]          crit_reg;

    logic [rood_pkg::DIST_W-1:0]          store_mem [rood_pkg::SAMPLES];
    logic                                 good_mem  [rood_pkg::SAMPLES];

    logic                                 s_accept;
    logic                                 gated;
    logic                                 last_sample;
    logic                                 last_idx;
    logic [rood_pkg::DIST_W-1:0]          rd_dist_reg;
    logic                                 rd_good_reg;

    logic [rood_pkg::CNT_W:0]             rem_shift;
    logic [rood_pkg::CNT_W+1:0]           trial;
    logic [rood_pkg::DIST_W-1:0]          avg;
    logic [rood_pkg::DIST_W-1:0]          lim;
    logic [rood_pkg::DIST_W-1:0]          diff;
    logic                                 keep;
    logic                                 in_window;
    logic [1:0]                           kept_sat;
    logic [1:0]                           obs_sat;

    assign s_axis_tready = (state_reg == IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign gated         = !enable_reg || !s_axis_tuser[1];
    assign last_sample   = (32'(pos_reg) == rood_pkg::SAMPLES - 1);
    assign last_idx      = (32'(idx_reg) == rood_pkg::SAMPLES - 1);

    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Restoring division step: one quotient bit per cycle.
    assign rem_shift = {rem_reg, acc_reg[rood_pkg::SUM_W-1]};
    assign trial     = {1'b0, rem_shift} - (rood_pkg::CNT_W + 2)'(cnt_reg);

    // After the divide, the quotient sits in the accumulator and fits a distance.
    assign avg  = acc_reg[rood_pkg::DIST_W-1:0];
    assign lim  = avg >> 1;
    assign diff = (rd_dist_reg >= avg) ? (rd_dist_reg - avg) : (avg - rd_dist_reg);
    assign keep = rd_good_reg && (diff < lim);
    assign in_window = (rd_dist_reg >= low_reg) && (rd_dist_reg <= crit_reg);

    assign kept_sat = (32'(kept_reg) > 3) ? 2'd3 : kept_reg[1:0];
    assign obs_sat  = (32'(obs_reg) > 3) ? 2'd3 : obs_reg[1:0];

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        kept_next    = kept_reg;
        obs_next     = obs_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (s_accept)
                begin
                    if (gated)
                    begin
                        pos_next    = '0;
                        status_next = rood_pkg::ST_INACTIVE;
                        kept_next   = '0;
                        obs_next    = '0;
                        mask_next   = '0;
                        state_next  = RESULT;
                    end
                    else if (last_sample)
                    begin
                        pos_next   = '0;
                        idx_next   = '0;
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = SUM;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end

            SUM:
            begin
                if (rd_good_reg)
                begin
                    acc_next = acc_reg + rood_pkg::SUM_W'(rd_dist_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next = '0;
                    rem_next = '0;
                    bit_next = rood_pkg::BIT_W'(rood_pkg::SUM_W - 1);
                    if (cnt_next == '0)
                    begin
                        status_next = rood_pkg::ST_ALL_FAILED;
                        kept_next   = '0;
                        obs_next    = '0;
                        mask_next   = '0;
                        state_next  = RESULT;
                    end
                    else
                    begin
                        state_next = DIV;
                    end
                end
            end

            DIV:
            begin
                if (!trial[rood_pkg::CNT_W+1])
                begin
                    rem_next = trial[rood_pkg::CNT_W-1:0];
                    acc_next = {acc_reg[rood_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[rood_pkg::CNT_W-1:0];
                    acc_next = {acc_reg[rood_pkg::SUM_W-2:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    kept_next  = '0;
                    obs_next   = '0;
                    mask_next  = '0;
                    state_next = CHECK;
                end
            end

            CHECK:
            begin
                if (keep)
                begin
                    kept_next = kept_reg + 1'b1;
                    if (in_window)
                    begin
                        obs_next  = obs_reg + 1'b1;
                        // Samples past the third shift out of the mask.
                        mask_next = mask_reg | rood_pkg::MASK_W'(8'b1 << idx_reg);
                    end
                end
                idx_next = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next = '0;
                    if (32'(kept_next) < 2)
                    begin
                        status_next = rood_pkg::ST_TOO_FEW;
                    end
                    else if (obs_next == kept_next)
                    begin
                        status_next = rood_pkg::ST_OBSTRUCTION;
                    end
                    else
                    begin
                        status_next = rood_pkg::ST_CLEAR;
                    end
                    state_next = RESULT;
                end
            end

            RESULT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {1'b0, mask_reg, obs_sat, kept_sat};
                    state_next   = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            pos_reg     <= '0;
            idx_reg     <= '0;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        kept_reg   <= kept_next;
        obs_reg    <= obs_next;
        mask_reg   <= mask_next;
        status_reg <= status_next;
    end

    // Sample store: written at the group position on each ungated beat. The read
    // uses the next index, so the registered data lines up with idx_reg.
    always_ff @(posedge clk)
    begin
        if (s_accept && !gated)
        begin
            store_mem[pos_reg] <= s_axis_tdata;
            good_mem[pos_reg]  <= s_axis_tuser[0];
        end
        rd_dist_reg <= store_mem[idx_next];
        rd_good_reg <= good_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            low_reg    <= rood_pkg::LOW_LIMIT_RST;
            crit_reg   <= rood_pkg::CRITICAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rood_pkg::CFG_ENABLE:    enable_reg <= cfg_data[0];
                rood_pkg::CFG_LOW_LIMIT: low_reg    <= cfg_data;
                rood_pkg::CFG_CRITICAL:  crit_reg   <= cfg_data;
                default:                 ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_gated_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && gated) |=> (state_reg == RESULT && pos_reg == '0))
        else $error("gated beat did not go straight to a result");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < rood_pkg::SAMPLES)
        else $error("group position out of range");

    a_obs_le_kept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:2] <= m_axis_tdata[1:0]))
        else $error("obstruction count exceeds kept count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= rood_pkg::ST_OBSTRUCTION))
        else $error("result status out of range");
`endif

endmodule

@@ bench/range_outlier_obstacle_detector_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_outlier_obstacle_detector_unit_test
// Self-checking bench for the obstacle detector. A short table of directed
// samples runs first, then random phases of mostly well-formed sample groups
// under changing limits and back-pressure. A behavioral copy of the group
// evaluation predicts each status beat that the table does not give, and every
// beat that leaves the block is compared with the oldest expected beat.
// ----------------------------------------------------------------------------
module range_outlier_obstacle_detector_unit_test;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic [rood_pkg::STATUS_W-1:0] status;
        logic [rood_pkg::COUNT_W-1:0]  kept;
        logic [rood_pkg::COUNT_W-1:0]  obstructions;
        logic [rood_pkg::MASK_W-1:0]   mask;
    } detect_result_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [rood_pkg::CFG_IDX_W-1:0]  reg_index;
        logic [rood_pkg::CFG_DATA_W-1:0] reg_value;
        logic [rood_pkg::DIST_W-1:0]     distance;
        logic                            sensor_ok;
        logic                            moving;
        logic                            typed;
        detect_result_t                  want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [15:0]                     s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [7:0]                      m_axis_tdata;
    logic [rood_pkg::STATUS_W-1:0]   m_axis_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rood_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rood_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the configuration and of the group under collection.
    logic                            det_enable = 1'b0;
    logic [rood_pkg::DIST_W-1:0]     det_low = rood_pkg::LOW_LIMIT_RST;
    logic [rood_pkg::DIST_W-1:0]     det_critical = rood_pkg::CRITICAL_RST;
    logic [rood_pkg::DIST_W-1:0]     group_dist [rood_pkg::SAMPLES];
    logic                            group_good [rood_pkg::SAMPLES];
    int unsigned                     group_pos = 0;

    detect_result_t                  pending_status [$];

    int unsigned                     error_count = 0;
    int unsigned                     cycle_count = 0;
    int unsigned                     send_idle_pct = 0;
    int unsigned                     recv_idle_pct = 0;
    int unsigned                     hold_requests = 0;
    int unsigned                     holds_served = 0;
    int unsigned                     hold_left = 0;

    range_outlier_obstacle_detector_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Group evaluation: mean of the good samples, outlier rejection against
    // half the mean, then the obstruction window on the survivors.
    function automatic bit predict_detection(input logic [rood_pkg::DIST_W-1:0] range_cm,
                                             input logic ok, input logic fwd,
                                             output detect_result_t res);
        int unsigned pos;
        int unsigned sum;
        int unsigned cnt;
        int unsigned avg;
        int unsigned lim;
        int unsigned diff;
        int unsigned kept;
        int unsigned obs;
        res = '0;
        res.status = rood_pkg::ST_INACTIVE;
        if (!det_enable || !fwd)
        begin
            group_pos = 0;
            return 1'b1;
        end
        pos = (group_pos >= rood_pkg::SAMPLES) ? 0 : group_pos;
        group_dist[pos] = range_cm;
        group_good[pos] = ok;
        if (pos + 1 < rood_pkg::SAMPLES)
        begin
            group_pos = pos + 1;
            return 1'b0;
        end
        group_pos = 0;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < rood_pkg::SAMPLES; i++)
        begin
            if (group_good[i])
            begin
                sum += group_dist[i];
                cnt++;
            end
        end
        if (cnt == 0)
        begin
            res.status = rood_pkg::ST_ALL_FAILED;
            return 1'b1;
        end
        avg = sum / cnt;
        lim = avg / 2;
        kept = 0;
        obs = 0;
        for (int i = 0; i < rood_pkg::SAMPLES; i++)
        begin
            if (group_good[i])
            begin
                diff = (group_dist[i] >= avg) ? group_dist[i] - avg : avg - group_dist[i];
                if (diff < lim)
                begin
                    kept++;
                    if (group_dist[i] >= det_low && group_dist[i] <= det_critical)
                    begin
                        obs++;
                        if (i < rood_pkg::MASK_W)
                            res.mask[i] = 1'b1;
                    end
                end
            end
        end
        if (kept < 2)
            res.status = rood_pkg::ST_TOO_FEW;
        else if (obs == kept)
            res.status = rood_pkg::ST_OBSTRUCTION;
        else
            res.status = rood_pkg::ST_CLEAR;
        res.kept = (kept > 3) ? 2'd3 : kept[rood_pkg::COUNT_W-1:0];
        res.obstructions = (obs > 3) ? 2'd3 : obs[rood_pkg::COUNT_W-1:0];
        return 1'b1;
    endfunction

    function automatic stim_row_t sample_row(input logic [rood_pkg::DIST_W-1:0] range_cm,
                                             input logic ok, input logic fwd);
        stim_row_t row;
        row = '0;
        row.kind = ROW_SAMPLE;
        row.distance = range_cm;
        row.sensor_ok = ok;
        row.moving = fwd;
        return row;
    endfunction

    function automatic stim_row_t checked_row(input logic [rood_pkg::DIST_W-1:0] range_cm,
                                              input logic ok, input logic fwd,
                                              input logic [rood_pkg::STATUS_W-1:0] st,
                                              input logic [rood_pkg::COUNT_W-1:0] k,
                                              input logic [rood_pkg::COUNT_W-1:0] o,
                                              input logic [rood_pkg::MASK_W-1:0] m);
        stim_row_t row;
        row = sample_row(range_cm, ok, fwd);
        row.typed = 1'b1;
        row.want = {st, k, o, m};
        return row;
    endfunction

    function automatic stim_row_t config_row(input logic [rood_pkg::CFG_IDX_W-1:0] idx,
                                             input logic [rood_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    task automatic write_register(input logic [rood_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [rood_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rood_pkg::CFG_ENABLE:    det_enable = val[0];
            rood_pkg::CFG_LOW_LIMIT: det_low = val;
            rood_pkg::CFG_CRITICAL:  det_critical = val;
            default:                 ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Entered and left at a falling edge; tvalid stays high for a following beat.
    task automatic offer_sample(input logic [rood_pkg::DIST_W-1:0] range_cm, input logic ok,
                                input logic fwd, input logic typed,
                                input detect_result_t want);
        detect_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= range_cm;
        s_axis_tuser <= {fwd, ok};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (predict_detection(range_cm, ok, fwd, res))
            pending_status.push_back(typed ? want : res);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        detect_result_t got;
        detect_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tuser;
            got.kept = m_axis_tdata[1:0];
            got.obstructions = m_axis_tdata[3:2];
            got.mask = m_axis_tdata[6:4];
            if (pending_status.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat, expected none, got status %0d kept %0d",
                         $time, got.status, got.kept);
                $display("%0t:   got obs %0d mask %b", $time, got.obstructions, got.mask);
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.status !== want.status || got.kept !== want.kept ||
                    got.obstructions !== want.obstructions || got.mask !== want.mask)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected status %0d kept %0d obs %0d mask %b",
                             $time, want.status, want.kept, want.obstructions, want.mask);
                    $display("%0t:   got status %0d kept %0d obs %0d mask %b",
                             $time, got.status, got.kept, got.obstructions, got.mask);
                end
            end
        end
    end

    initial
    begin
        stim_row_t   dir_table [$];
        int          center;
        int          spread;
        int          jitter;
        int          lo;
        int          hi;
        int          v;
        int unsigned pick;
        logic        ok;
        logic        fwd;

        // After reset the block is disabled, so every sample is inactive.
        dir_table.push_back(checked_row(16'd100, 1'b1, 1'b1, rood_pkg::ST_INACTIVE,
                                        2'd0, 2'd0, 3'd0));
        dir_table.push_back(checked_row(16'd0, 1'b0, 1'b0, rood_pkg::ST_INACTIVE,
                                        2'd0, 2'd0, 3'd0));
        dir_table.push_back(config_row(rood_pkg::CFG_ENABLE, 16'd1));
        dir_table.push_back(sample_row(16'hFFFF, 1'b0, 1'b1));
        dir_table.push_back(sample_row(16'd0, 1'b0, 1'b1));
        dir_table.push_back(checked_row(16'd1234, 1'b0, 1'b1, rood_pkg::ST_ALL_FAILED,
                                        2'd0, 2'd0, 3'd0));
        dir_table.push_back(sample_row(16'd15, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd15, 1'b1, 1'b1));
        dir_table.push_back(checked_row(16'd15, 1'b1, 1'b1, rood_pkg::ST_OBSTRUCTION,
                                        2'd3, 2'd3, 3'd7));
        dir_table.push_back(sample_row(16'd100, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd100, 1'b1, 1'b1));
        dir_table.push_back(checked_row(16'd100, 1'b1, 1'b1, rood_pkg::ST_CLEAR,
                                        2'd3, 2'd0, 3'd0));
        // A mean of 0 or 1 leaves no rejection margin.
        dir_table.push_back(sample_row(16'd1, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd0, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd2, 1'b1, 1'b1));
        // The third sample lies exactly at the rejection margin.
        dir_table.push_back(sample_row(16'd14, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd16, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd30, 1'b1, 1'b1));
        // Stopping in the middle of a group restarts it.
        dir_table.push_back(sample_row(16'd15, 1'b1, 1'b1));
        dir_table.push_back(checked_row(16'd15, 1'b1, 1'b0, rood_pkg::ST_INACTIVE,
                                        2'd0, 2'd0, 3'd0));
        dir_table.push_back(config_row(rood_pkg::CFG_LOW_LIMIT, 16'd0));
        dir_table.push_back(config_row(rood_pkg::CFG_CRITICAL, 16'd65534));
        dir_table.push_back(sample_row(16'hFFFF, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'hFFFF, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd65534, 1'b1, 1'b1));
        // Inverted window: nothing can be an obstruction.
        dir_table.push_back(config_row(rood_pkg::CFG_LOW_LIMIT, 16'd30));
        dir_table.push_back(config_row(rood_pkg::CFG_CRITICAL, 16'd20));
        dir_table.push_back(sample_row(16'd25, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd25, 1'b1, 1'b1));
        dir_table.push_back(sample_row(16'd25, 1'b1, 1'b1));
        dir_table.push_back(config_row(rood_pkg::CFG_ENABLE, 16'd0));
        dir_table.push_back(checked_row(16'd50, 1'b1, 1'b1, rood_pkg::ST_INACTIVE,
                                        2'd0, 2'd0, 3'd0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 55;
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CONFIG)
            begin
                s_axis_tvalid <= 1'b0;
                wait_results_drained();
                write_register(dir_table[i].reg_index, dir_table[i].reg_value);
            end
            else
                offer_sample(dir_table[i].distance, dir_table[i].sensor_ok,
                             dir_table[i].moving, dir_table[i].typed, dir_table[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            s_axis_tvalid <= 1'b0;
            wait_results_drained();
            if (ph < 4)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 55;
            end
            else if (ph < 8)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(2))
                0:       center = $urandom_range(40);
                1:       center = $urandom_range(3000);
                default: center = $urandom_range(65535);
            endcase
            spread = $urandom_range(center / 3 + 5);
            lo = (center - spread < 0) ? 0 : center - spread;
            hi = (center + spread > 65534) ? 65534 : center + spread;
            if (ph == 2)
            begin
                lo = 0;
                hi = 65534;
            end
            else if (ph == 3)
            begin
                lo = 65534;
                hi = 0;
            end
            else if (ph == 9)
            begin
                lo = (center > 65534) ? 65534 : center;
                hi = lo;
            end
            if (ph == 0)
                write_register(rood_pkg::CFG_ENABLE, 16'd1);
            else if (ph == 5)
                write_register(rood_pkg::CFG_ENABLE, 16'd0);
            else
                write_register(rood_pkg::CFG_ENABLE,
                               ($urandom_range(9) != 0) ? 16'd1 : 16'd0);
            write_register(rood_pkg::CFG_LOW_LIMIT, lo[15:0]);
            write_register(rood_pkg::CFG_CRITICAL, hi[15:0]);
            jitter = center / 4 + 3;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Long receiver hold-off while the sender keeps offering.
                if (ph == 1 && n == 30)
                    hold_requests++;
                if (ph == 6 && n == 50)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_results_drained();
                end
                fwd = ($urandom_range(99) >= 4);
                ok = ($urandom_range(99) >= 12);
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    v = center + int'($urandom_range(2 * jitter)) - jitter;
                    if (v < 0)
                        v = 0;
                    if (v > 65535)
                        v = 65535;
                end
                else if (pick < 85)
                    v = $urandom_range(65535);
                else if (pick < 92)
                    v = $urandom_range(3);
                else
                begin
                    case ($urandom_range(2))
                        0:       v = 65535;
                        1:       v = 65534;
                        default: v = 0;
                    endcase
                end
                offer_sample(v[15:0], ok, fwd, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_results_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
